// File: sv/i2ccd_pkg.sv
// Shared types and constants for the I2C SCL divider best-fit search.
package i2ccd_pkg;

  // Field widths
  localparam int unsigned ClkW    = 28;
  localparam int unsigned RateW   = 20;
  localparam int unsigned CodeW   = 2;
  localparam int unsigned IdxW    = 6;
  localparam int unsigned DivisorW = 12;
  localparam int unsigned CntW    = $clog2(ClkW);

  // Reset value of the bus clock register
  localparam logic [ClkW-1:0] BusClockReset = 28'd60000000;

  // SCL divider ROM
  localparam logic [DivisorW-1:0] SclDivRom [64] = '{
    12'd20,   12'd22,   12'd24,   12'd26,   12'd28,   12'd30,   12'd34,   12'd40,
    12'd28,   12'd32,   12'd36,   12'd40,   12'd44,   12'd48,   12'd56,   12'd68,
    12'd48,   12'd56,   12'd64,   12'd72,   12'd80,   12'd88,   12'd104,  12'd128,
    12'd80,   12'd96,   12'd112,  12'd128,  12'd144,  12'd160,  12'd192,  12'd240,
    12'd160,  12'd192,  12'd224,  12'd256,  12'd288,  12'd320,  12'd384,  12'd480,
    12'd320,  12'd384,  12'd448,  12'd512,  12'd576,  12'd640,  12'd768,  12'd960,
    12'd640,  12'd768,  12'd896,  12'd1024, 12'd1152, 12'd1280, 12'd1536, 12'd1920,
    12'd1280, 12'd1536, 12'd1792, 12'd2048, 12'd2304, 12'd2560, 12'd3072, 12'd3840
  };

  // Search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIVIDE,
    ST_DIFF,
    ST_COMPARE,
    ST_DONE
  } search_state_e;

endpackage

// File: sv/i2ccd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
module i2ccd_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [i2ccd_pkg::ClkW-1:0]       dividend_i,
  input  logic [i2ccd_pkg::DivisorW-1:0]   divisor_i,
  output logic                             done_o,
  output logic [i2ccd_pkg::ClkW-1:0]       quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [i2ccd_pkg::CntW-1:0]       cnt_q, cnt_d;
  logic [i2ccd_pkg::DivisorW-1:0]   rem_q, rem_d;
  logic [i2ccd_pkg::DivisorW-1:0]   dvs_q, dvs_d;
  logic [i2ccd_pkg::ClkW-1:0]       shift_q, shift_d;
  logic [i2ccd_pkg::DivisorW:0]     trial;
  logic [i2ccd_pkg::DivisorW:0]     trial_sub;
  logic                             fits;

  // One restoring step: bring in the next dividend bit, try to subtract
  assign trial     = {rem_q, shift_q[i2ccd_pkg::ClkW-1]};
  assign trial_sub = trial - {1'b0, dvs_q};
  assign fits      = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    shift_d = shift_q;
    if (start_i) begin
      busy_d  = 1'b1;
      cnt_d   = '0;
      rem_d   = '0;
      dvs_d   = divisor_i;
      shift_d = dividend_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits suffice
      rem_d   = fits ? trial_sub[i2ccd_pkg::DivisorW-1:0] : trial[i2ccd_pkg::DivisorW-1:0];
      shift_d = {shift_q[i2ccd_pkg::ClkW-2:0], fits};
      cnt_d   = cnt_q + i2ccd_pkg::CntW'(1);
      if (cnt_q == i2ccd_pkg::CntW'(i2ccd_pkg::ClkW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    dvs_q   <= dvs_d;
    shift_q <= shift_d;
  end

  assign done_o     = done_q;
  assign quotient_o = shift_q;

endmodule

// File: sv/i2c_clock_divider_search.sv
// Top level: best-fit search over multiplier codes and SCL divider ROM entries.
// Per candidate the sequencer steps through ST_LOAD, ST_DIVIDE (waiting on the bit-serial
// divider), ST_DIFF and ST_COMPARE. A new item is taken once the search ends and its result
// is loaded into the output register, where that result may still wait.
// Reset: asynchronous active low; bus clock register returns to 60000000, no result pending.
module i2c_clock_divider_search #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MULT_STEPS    = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [27:0] cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [19:0] target_rate, [23:20] zero
  // output stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] mult_code, [7:2] divider_index,
                                        // [13:8] divider_index, [15:14] mult_code
);

  i2ccd_pkg::search_state_e state_q, state_d;

  logic [i2ccd_pkg::ClkW-1:0]  bus_clk_q;
  logic [i2ccd_pkg::RateW-1:0] target_q;
  logic [i2ccd_pkg::CodeW-1:0] code_q, code_d;
  logic [i2ccd_pkg::IdxW-1:0]  idx_q, idx_d;
  logic [i2ccd_pkg::CodeW-1:0] best_code_q, best_code_d;
  logic [i2ccd_pkg::IdxW-1:0]  best_idx_q, best_idx_d;
  logic [i2ccd_pkg::ClkW-1:0]  min_err_q, min_err_d;
  logic                        have_best_q, have_best_d;
  logic [i2ccd_pkg::ClkW-1:0]  diff_q;
  logic [i2ccd_pkg::ClkW-1:0]  target_ext;
  logic                        out_valid_q;
  logic [i2ccd_pkg::CodeW-1:0] out_code_q;
  logic [i2ccd_pkg::IdxW-1:0]  out_idx_q;

  logic                        in_xact;
  logic                        last_pair;
  logic                        div_start;
  logic                        div_done;
  logic [i2ccd_pkg::ClkW-1:0]  quot;
  logic                        load_out;

  assign in_xact    = s_axis_tvalid_i && s_axis_tready_o;
  assign last_pair  = (code_q == i2ccd_pkg::CodeW'(MULT_STEPS - 1)) &&
                      (idx_q == i2ccd_pkg::IdxW'(TABLE_ENTRIES - 1));
  assign target_ext = {{(i2ccd_pkg::ClkW - i2ccd_pkg::RateW){1'b0}}, target_q};

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bus_clk_q <= i2ccd_pkg::BusClockReset;
    end else if (cfg_we_i) begin
      bus_clk_q <= cfg_wdata_i;
    end
  end

  // Serial divider; the multiplier factor is a right shift of the dividend
  i2ccd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (bus_clk_q >> code_q),
    .divisor_i  (i2ccd_pkg::SclDivRom[idx_q]),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      i2ccd_pkg::ST_IDLE:    if (s_axis_tvalid_i) state_d = i2ccd_pkg::ST_LOAD;
      i2ccd_pkg::ST_LOAD:    state_d = i2ccd_pkg::ST_DIVIDE;
      i2ccd_pkg::ST_DIVIDE:  if (div_done) state_d = i2ccd_pkg::ST_DIFF;
      i2ccd_pkg::ST_DIFF:    state_d = i2ccd_pkg::ST_COMPARE;
      i2ccd_pkg::ST_COMPARE: state_d = last_pair ? i2ccd_pkg::ST_DONE : i2ccd_pkg::ST_LOAD;
      i2ccd_pkg::ST_DONE:    if (!out_valid_q || m_axis_tready_i) state_d = i2ccd_pkg::ST_IDLE;
      default:               state_d = i2ccd_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    load_out        = 1'b0;
    unique case (state_q)
      i2ccd_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      i2ccd_pkg::ST_LOAD: div_start = 1'b1;
      i2ccd_pkg::ST_DONE: load_out = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  // Candidate counters and best-so-far tracking
  always_comb begin
    code_d      = code_q;
    idx_d       = idx_q;
    best_code_d = best_code_q;
    best_idx_d  = best_idx_q;
    min_err_d   = min_err_q;
    have_best_d = have_best_q;
    if (in_xact) begin
      code_d      = '0;
      idx_d       = '0;
      have_best_d = 1'b0;
    end else if (state_q == i2ccd_pkg::ST_COMPARE) begin
      // strict compare keeps the first pair on ties
      if (!have_best_q || (diff_q < min_err_q)) begin
        have_best_d = 1'b1;
        min_err_d   = diff_q;
        best_code_d = code_q;
        best_idx_d  = idx_q;
      end
      if (idx_q == i2ccd_pkg::IdxW'(TABLE_ENTRIES - 1)) begin
        idx_d  = '0;
        code_d = code_q + i2ccd_pkg::CodeW'(1);
      end else begin
        idx_d = idx_q + i2ccd_pkg::IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= i2ccd_pkg::ST_IDLE;
      code_q      <= '0;
      idx_q       <= '0;
      have_best_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      code_q      <= code_d;
      idx_q       <= idx_d;
      have_best_q <= have_best_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_xact) begin
      target_q <= s_axis_tdata_i[i2ccd_pkg::RateW-1:0];
    end
    if (state_q == i2ccd_pkg::ST_DIFF) begin
      diff_q <= (target_ext > quot) ? (target_ext - quot) : (quot - target_ext);
    end
    best_code_q <= best_code_d;
    best_idx_q  <= best_idx_d;
    min_err_q   <= min_err_d;
    if (load_out) begin
      out_code_q <= best_code_q;
      out_idx_q  <= best_idx_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_code_q, out_idx_q, out_idx_q, out_code_q};

endmodule
